// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk; GRK_ASSERT is disabled by rst
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define GRK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every edge
`define GRK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/grk_pkg.sv
// ---------------------------------------------------------------------------
// grk_pkg
// types, widths and the ordering function shared by the ranker modules
// ---------------------------------------------------------------------------
package grk_pkg;

  localparam int IDX_W = 6;
  localparam int CNT_W = 7;

  typedef struct packed {
    logic signed [8:0] tgt_id;
    logic [30:0]       start_pos;
    logic [30:0]       stop_pos;
    logic              last_record;
  } rec_t;

  typedef struct packed {
    logic [IDX_W-1:0] record_index;
    logic [IDX_W-1:0] order_rank;
    logic             end_of_run;
  } rank_t;

  // sort key, unaligned flag on top so aligned records sort first
  typedef struct packed {
    logic        unal;
    logic [7:0]  tgt;
    logic [31:0] mid;
  } key_t;

  typedef struct packed {
    key_t             key;
    logic [IDX_W-1:0] idx;
  } travel_t;

  typedef struct packed {
    logic prep;
    logic step;
    logic shift;
  } ctl_t;

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_PREP = 4'b0010,
    ST_RANK = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  function automatic logic comes_before(travel_t a, travel_t b);
    return {a.key, a.idx} < {b.key, b.idx};
  endfunction

endpackage

// File: design/genome_order_ranker.sv
// ---------------------------------------------------------------------------
// genome_order_ranker
// ranks loaded records by alignment, target id, midpoint and index
// ---------------------------------------------------------------------------
// Records enter on rec (rec_valid / rec_stall), one per cycle while rec_stall
// is low, in index order. Each goes into its own cell of a chain of
// MAX_RECORDS cells; records past MAX_RECORDS are dropped. The record with
// last_record set starts ranking: rec_stall rises, the prep state loads
// the circulating keys, then the rank state rotates every key once around
// the ring while each cell counts the keys that sort before its own. Ranks
// then shift out of cell 0 on rank (rank_valid / rank_stall), one per cycle
// in index order, end_of_run set on the last one.
// Loading of the next set starts once the last rank sits in the output
// register. A stall on rank holds the output register and pauses the shift.
// Reset empties the record count and the output; cell contents are not reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module genome_order_ranker import grk_pkg::*; #(
  parameter int MAX_RECORDS = 64,
  parameter int MAX_TARGETS = 256
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  rec_valid,
  output logic  rec_stall,
  input  rec_t  rec,
  output logic  rank_valid,
  input  logic  rank_stall,
  output rank_t rank
);

  localparam int SW = (MAX_RECORDS > 2) ? $clog2(MAX_RECORDS - 1) : 1;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] n_reg;
  logic [CNT_W-1:0] emit_cnt;
  logic [SW-1:0]    step_cnt;

  logic             accept;
  logic             room;
  logic             aligned;
  logic [31:0]      mid_sum;
  key_t             new_key;
  logic             out_load;
  logic             last_emit;
  ctl_t             ctl;

  travel_t          own_a  [MAX_RECORDS];
  travel_t          trav_a [MAX_RECORDS];
  logic [IDX_W-1:0] rank_a [MAX_RECORDS];

  assign rec_stall = (state != ST_LOAD);
  assign accept    = rec_valid && !rec_stall;
  assign room      = (count < CNT_W'(MAX_RECORDS));

  assign aligned = !rec.tgt_id[8] && (32'(rec.tgt_id[7:0]) < 32'(MAX_TARGETS));
  assign mid_sum = {1'b0, rec.start_pos} + {1'b0, rec.stop_pos};
  assign new_key = '{unal: !aligned,
                     tgt:  aligned ? rec.tgt_id[7:0] : 8'd0,
                     mid:  aligned ? {1'b0, mid_sum[31:1]} : 32'd0};

  assign out_load  = (state == ST_EMIT) && (!rank_valid || !rank_stall);
  assign last_emit = (emit_cnt + CNT_W'(1) == n_reg);

  assign ctl = '{prep:  (state == ST_PREP),
                 step:  (state == ST_RANK),
                 shift: out_load};

  for (genvar k = 0; k < MAX_RECORDS; k++) begin : g_cell
    grk_cell #(.POS(k)) u_cell (
      .clk       (clk),
      .wr_en     (accept && (count == CNT_W'(k))),
      .wr_key    (new_key),
      .ctl       (ctl),
      .n         (n_reg),
      .prev_own  (own_a[(k + MAX_RECORDS - 1) % MAX_RECORDS]),
      .travel_in (trav_a[(k + MAX_RECORDS - 1) % MAX_RECORDS]),
      .rank_in   ((k == MAX_RECORDS - 1) ? '0 : rank_a[(k + 1) % MAX_RECORDS]),
      .own       (own_a[k]),
      .travel    (trav_a[k]),
      .rank      (rank_a[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      count      <= '0;
      n_reg      <= '0;
      emit_cnt   <= '0;
      step_cnt   <= '0;
      rank_valid <= 1'b0;
    end else begin
      if (out_load) begin
        rank_valid <= 1'b1;
      end else if (!rank_stall) begin
        rank_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (rec.last_record) begin
              n_reg <= room ? count + CNT_W'(1) : count;
              count <= '0;
              state <= ST_PREP;
            end else if (room) begin
              count <= count + CNT_W'(1);
            end
          end
        end
        ST_PREP: begin
          step_cnt <= '0;
          state    <= ST_RANK;
        end
        ST_RANK: begin
          step_cnt <= step_cnt + SW'(1);
          if (step_cnt == SW'(MAX_RECORDS - 2)) begin
            emit_cnt <= '0;
            state    <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            emit_cnt <= emit_cnt + CNT_W'(1);
            if (last_emit) begin
              state <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rank <= '{record_index: emit_cnt[IDX_W-1:0],
                order_rank:   rank_a[0],
                end_of_run:   last_emit};
    end
  end

  `GRK_ASSERT(a_rank_hold, rank_valid && rank_stall |=> rank_valid && $stable(rank), "stalled rank changed")
  `GRK_ASSERT(a_rank_steps, state == ST_RANK |=> (state == ST_RANK && step_cnt == $past(step_cnt) + SW'(1)) || state == ST_EMIT, "ranking pass skipped a step")
  `GRK_ASSERT(a_count_bound, count <= CNT_W'(MAX_RECORDS), "record count beyond capacity")
  `GRK_ASSERT_ALWAYS(a_reset_clears, rst |=> !rank_valid && state == ST_LOAD, "reset left output or state busy")

endmodule

// File: design/grk_cell.sv
// ---------------------------------------------------------------------------
// grk_cell
// one record slot: holds a key, compares a passing key and counts its rank
// ---------------------------------------------------------------------------
module grk_cell import grk_pkg::*; #(
  parameter int POS = 0
) (
  input  logic             clk,
  input  logic             wr_en,
  input  key_t             wr_key,
  input  ctl_t             ctl,
  input  logic [CNT_W-1:0] n,
  input  travel_t          prev_own,
  input  travel_t          travel_in,
  input  logic [IDX_W-1:0] rank_in,
  output travel_t          own,
  output travel_t          travel,
  output logic [IDX_W-1:0] rank
);

  key_t key;
  logic hit;

  assign own = '{key: key, idx: IDX_W'(POS)};
  assign hit = ({1'b0, travel.idx} < n) && comes_before(travel, own);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key <= wr_key;
    end
    if (ctl.prep) begin
      travel <= prev_own;
      rank   <= '0;
    end else if (ctl.step) begin
      travel <= travel_in;
      if (hit) begin
        rank <= rank + IDX_W'(1);
      end
    end else if (ctl.shift) begin
      rank <= rank_in;
    end
  end

endmodule

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// genome_order_ranker testbench
// loads record sets through the rec channel and checks every rank against
// an in-bench ordering of target id, midpoint and index; directed sets cover
// field extremes, ties, unaligned ids and a full store, then random sets
// run with random gaps on the sender and random stalls on the receiver
// ---------------------------------------------------------------------------
module tb;
  import grk_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RECORD_SLOTS = 64;
  localparam int TARGET_LIMIT = 256;
  localparam int RANDOM_RECORDS = 190;
  localparam int MAX_REPORTS = 10;

  localparam int STYLE_TIES = 0;
  localparam int STYLE_WIDE = 1;
  localparam int STYLE_UNMAPPED = 2;

  logic  clk = 1'b0;
  logic  rst;
  logic  rec_valid;
  logic  rec_stall;
  rec_t  rec;
  logic  rank_valid;
  logic  rank_stall;
  rank_t rank;

  logic signed [8:0] held_target [RECORD_SLOTS];
  logic [31:0]       held_mid [RECORD_SLOTS];
  int                held_count;
  rank_t             pending_ranks [$];

  int gap_max;
  int stall_max;
  int records_sent;
  int sets_sent;
  int ranks_checked;
  int mismatches;
  int stray_failures;

  genome_order_ranker #(
    .MAX_RECORDS(RECORD_SLOTS),
    .MAX_TARGETS(TARGET_LIMIT)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .rec_valid(rec_valid),
    .rec_stall(rec_stall),
    .rec(rec),
    .rank_valid(rank_valid),
    .rank_stall(rank_stall),
    .rank(rank)
  );

  always #6 clk = ~clk;

  function automatic bit is_mapped(logic signed [8:0] t);
    int v;
    v = int'(t);
    return v >= 0 && v < TARGET_LIMIT;
  endfunction

  // genome order of held records a and b
  function automatic bit sorts_ahead(int a, int b);
    bit map_a;
    bit map_b;
    map_a = is_mapped(held_target[a]);
    map_b = is_mapped(held_target[b]);
    if (map_a != map_b) return map_a;
    if (!map_a) return a < b;
    if (held_target[a] != held_target[b]) return held_target[a] < held_target[b];
    if (held_mid[a] != held_mid[b]) return held_mid[a] < held_mid[b];
    return a < b;
  endfunction

  task automatic take_record(rec_t r);
    logic [31:0] sum;
    rank_t       want;
    int          pos;
    if (held_count < RECORD_SLOTS) begin
      sum = {1'b0, r.start_pos} + {1'b0, r.stop_pos};
      held_target[held_count] = r.tgt_id;
      held_mid[held_count] = sum >> 1;
      held_count++;
    end
    if (r.last_record) begin
      for (int i = 0; i < held_count; i++) begin
        pos = 0;
        for (int j = 0; j < held_count; j++) begin
          if (j != i && sorts_ahead(j, i)) pos++;
        end
        want.record_index = i[5:0];
        want.order_rank = pos[5:0];
        want.end_of_run = (i == held_count - 1);
        pending_ranks = {pending_ranks, want};
      end
      held_count = 0;
      sets_sent++;
    end
  endtask

  // one request per record, entered and left at a falling edge
  task automatic send_record(logic signed [8:0] tgt, logic [30:0] s, logic [30:0] e,
                             bit last);
    rec_t r;
    int   gap;
    r.tgt_id = tgt;
    r.start_pos = s;
    r.stop_pos = e;
    r.last_record = last;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      rec_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rec_valid <= 1'b1;
    rec <= r;
    @(posedge clk);
    while (rec_stall) @(posedge clk);
    take_record(r);
    records_sent++;
    @(negedge clk);
  endtask

  function automatic rec_t draw_record(int style);
    rec_t r;
    r.last_record = 1'b0;
    case (style)
      STYLE_TIES: begin
        r.tgt_id = ($urandom_range(0, 4) == 0) ? -9'sd1 : 9'($urandom_range(0, 3));
        r.start_pos = 31'($urandom_range(0, 20));
        r.stop_pos = 31'($urandom_range(0, 20));
      end
      STYLE_UNMAPPED: begin
        r.tgt_id = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 255))
                                               : 9'($urandom_range(256, 511));
        r.start_pos = 31'($urandom_range(0, 1000));
        r.stop_pos = 31'($urandom_range(0, 1000));
      end
      default: begin
        r.tgt_id = 9'($urandom_range(0, 511));
        r.start_pos = 31'($urandom());
        r.stop_pos = 31'($urandom());
        if ($urandom_range(0, 7) == 0) r.start_pos = '1;
        if ($urandom_range(0, 7) == 0) r.stop_pos = '1;
        if ($urandom_range(0, 7) == 0) r.stop_pos = '0;
      end
    endcase
    return r;
  endfunction

  task automatic run_set(int n, int style);
    rec_t r;
    for (int k = 0; k < n; k++) begin
      r = draw_record(style);
      send_record(r.tgt_id, r.start_pos, r.stop_pos, k == n - 1);
    end
  endtask

  task automatic test_directed_order;
    logic [30:0] top;
    top = '1;
    gap_max = 0;
    stall_max = 0;
    send_record(9'sd5, 31'd100, 31'd200, 1'b0);
    send_record(-9'sd1, 31'd0, 31'd0, 1'b0);
    send_record(9'sd0, top, top, 1'b0);
    // odd sum, truncates onto the first record's midpoint
    send_record(9'sd5, 31'd101, 31'd200, 1'b0);
    send_record(9'sd255, 31'd0, 31'd0, 1'b0);
    send_record(9'sd0, 31'd0, 31'd0, 1'b0);
    send_record(-9'sd256, top, 31'd0, 1'b0);
    send_record(9'sd5, 31'd0, 31'd299, 1'b0);
    send_record(-9'sd2, 31'd10, 31'd10, 1'b0);
    send_record(9'sd0, top, 31'd0, 1'b0);
    send_record(9'sd255, top, top, 1'b0);
    send_record(9'sd1, 31'd7, 31'd8, 1'b0);
    send_record(-9'sd1, top, top, 1'b1);
  endtask

  task automatic test_single_record;
    gap_max = 6;
    stall_max = 6;
    send_record(9'sd0, 31'd0, 31'd0, 1'b1);
    send_record(-9'sd1, 31'd5, 31'd9, 1'b1);
  endtask

  task automatic test_unmapped_only;
    gap_max = 6;
    stall_max = 0;
    send_record(-9'sd3, 31'd50, 31'd50, 1'b0);
    send_record(-9'sd1, 31'd0, 31'd0, 1'b0);
    send_record(-9'sd200, 31'd1, 31'd1, 1'b0);
    send_record(-9'sd1, 31'd0, 31'd0, 1'b1);
  endtask

  // two records past a full store, the second one closing the set
  task automatic test_store_full;
    gap_max = 2;
    stall_max = 6;
    run_set(RECORD_SLOTS + 2, STYLE_TIES);
    gap_max = 0;
    stall_max = 0;
    run_set(RECORD_SLOTS, STYLE_WIDE);
  endtask

  task automatic test_random_sets;
    int goal;
    int n;
    int pick;
    goal = records_sent + RANDOM_RECORDS;
    while (records_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) n = $urandom_range(1, 10);
      else if (pick < 95) n = $urandom_range(11, 40);
      else n = $urandom_range(60, RECORD_SLOTS + 2);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      stall_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      run_set(n, $urandom_range(STYLE_TIES, STYLE_UNMAPPED));
    end
  endtask

  // receiver: random hold-off before each rank
  initial begin : rank_sink
    int hold;
    rank_stall = 1'b0;
    forever begin
      @(negedge clk);
      hold = $urandom_range(0, stall_max);
      if (hold > 0) begin
        rank_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      rank_stall <= 1'b0;
      @(posedge clk);
      while (rst || !rank_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : rank_check
    rank_t want;
    if (!rst && rank_valid && !rank_stall) begin
      ranks_checked++;
      if (pending_ranks.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected rank: index %0d rank %0d end %0b",
                   rank.record_index, rank.order_rank, rank.end_of_run);
      end else begin
        want = pending_ranks.pop_front();
        if (rank.record_index !== want.record_index || rank.order_rank !== want.order_rank ||
            rank.end_of_run !== want.end_of_run) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("rank mismatch: exp index %0d rank %0d end %0b, got %0d %0d %0b",
                     want.record_index, want.order_rank, want.end_of_run,
                     rank.record_index, rank.order_rank, rank.end_of_run);
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int guard;
    rst = 1'b1;
    rec_valid = 1'b0;
    rec = '0;
    gap_max = 0;
    stall_max = 0;
    held_count = 0;
    records_sent = 0;
    sets_sent = 0;
    ranks_checked = 0;
    mismatches = 0;
    stray_failures = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_order();
    test_single_record();
    test_unmapped_only();
    test_store_full();
    test_random_sets();

    rec_valid <= 1'b0;
    guard = 0;
    while (pending_ranks.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (RECORD_SLOTS + 8) @(posedge clk);
    if (pending_ranks.size() != 0) begin
      stray_failures++;
      $display("%0d ranks never arrived", pending_ranks.size());
    end

    $display("covered directed ordering, single records, unaligned-only sets, a full store");
    $display("and random sets: %0d records in %0d sets, %0d ranks checked, %0d mismatches",
             records_sent, sets_sent, ranks_checked, mismatches);
    if (mismatches == 0 && stray_failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/grk_pkg.sv
design/grk_cell.sv
design/genome_order_ranker.sv
tb/tb.sv
